>>> hdl/pasl_pkg.sv
package pasl_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int KEY_W  = 64;
  localparam int CNT_W  = 7;
  localparam int STAT_W = 3;

  localparam logic [STAT_W-1:0] ST_DONE        = 3'd0;
  localparam logic [STAT_W-1:0] ST_TOTAL_FULL  = 3'd1;
  localparam logic [STAT_W-1:0] ST_AT_LIMIT    = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNKNOWN     = 3'd3;
  localparam logic [STAT_W-1:0] ST_TABLE_ERROR = 3'd4;

  localparam logic CMD_ADMIT   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic REG_PER_ADDR_LIMIT = 1'b0;
  localparam logic REG_TOTAL_LIMIT    = 1'b1;

  localparam logic [CNT_W-1:0] PER_ADDR_LIMIT_RST = 7'd4;
  localparam logic [CNT_W-1:0] TOTAL_LIMIT_RST    = 7'd64;

  // search token travelling down the cell chain
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic             free;
    logic [CNT_W-1:0] hit_cnt;
  } tok_t;

  // table write broadcast to all cells
  typedef struct packed {
    logic             en;
    logic             key_en;
    logic [CNT_W-1:0] cnt;
  } wr_t;

endpackage

>>> hdl/per_address_session_limiter.sv
// Channel | Dir | Handshake          | Contents
// in_     | in  | tvalid/tready      | tuser: command; tdata: address_key
// out_    | out | tvalid/tready      | tdata: status, address_sessions, total_sessions
// cfg_    | in  | we                 | index 0 per-address limit, 1 total limit
//
// For each request a search token walks the chain of table cells, one cell
// per cycle, then the result is written back.
// Reset clears all counts, the total and restores default limits; keys are
// not cleared since only live cells are ever compared.
// A new request is taken once the previous one has been written back, even
// while its result still waits in the output register.
module per_address_session_limiter #(
  parameter int TABLE_ENTRIES = pasl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] address_key
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] status, [9:3] address_sessions,
                                  // [16:10] total_sessions
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_wdata
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CW    = pasl_pkg::CNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic                       start_r;
  logic                       cmd_r;
  logic [pasl_pkg::KEY_W-1:0] key_r;
  logic                       hit_r, free_r;
  logic [CW-1:0]              hit_cnt_r;
  logic [IDX_W-1:0]           hit_idx_r, free_idx_r;
  logic [CW-1:0]              total_r, total_nxt;
  logic [CW-1:0]              per_lim_r, tot_lim_r;
  logic                       out_tvalid_r, out_tvalid_nxt;
  logic [23:0]                out_tdata_r;

  logic                       in_fire, out_load;
  logic [pasl_pkg::STAT_W-1:0] status;
  logic [CW-1:0]              addr_cnt;
  pasl_pkg::wr_t              wr;
  logic [IDX_W-1:0]           wr_idx;

  pasl_pkg::tok_t   tok      [0:TABLE_ENTRIES];
  logic [IDX_W-1:0] hit_idx  [0:TABLE_ENTRIES];
  logic [IDX_W-1:0] free_idx [0:TABLE_ENTRIES];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == S_FIN) && (!out_tvalid_r || out_tready);

  assign tok[0]      = '{valid: start_r, hit: 1'b0, free: 1'b0, hit_cnt: '0};
  assign hit_idx[0]  = '0;
  assign free_idx[0] = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    pasl_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .req_key      (key_r),
      .tok_in       (tok[i]),
      .hit_idx_in   (hit_idx[i]),
      .free_idx_in  (free_idx[i]),
      .tok_out      (tok[i+1]),
      .hit_idx_out  (hit_idx[i+1]),
      .free_idx_out (free_idx[i+1]),
      .wr           (wr),
      .wr_idx       (wr_idx)
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_SCAN;
      S_SCAN: if (tok[TABLE_ENTRIES].valid) state_nxt = S_FIN;
      S_FIN:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // decide the outcome from the search result
  always_comb begin
    status    = pasl_pkg::ST_DONE;
    addr_cnt  = hit_r ? hit_cnt_r : '0;
    total_nxt = total_r;
    wr        = '{en: 1'b0, key_en: 1'b0, cnt: '0};
    wr_idx    = hit_idx_r;
    if (cmd_r == pasl_pkg::CMD_ADMIT) begin
      if (total_r >= tot_lim_r) begin
        status = pasl_pkg::ST_TOTAL_FULL;
      end else if (hit_r) begin
        if (hit_cnt_r >= per_lim_r) begin
          status = pasl_pkg::ST_AT_LIMIT;
        end else begin
          addr_cnt  = hit_cnt_r + CW'(1);
          total_nxt = total_r + CW'(1);
          wr        = '{en: out_load, key_en: 1'b0, cnt: hit_cnt_r + CW'(1)};
        end
      end else if (free_r) begin
        addr_cnt  = CW'(1);
        total_nxt = total_r + CW'(1);
        wr        = '{en: out_load, key_en: 1'b1, cnt: CW'(1)};
        wr_idx    = free_idx_r;
      end else begin
        status = pasl_pkg::ST_TABLE_ERROR;
      end
    end else begin
      if (!hit_r) begin
        status = pasl_pkg::ST_UNKNOWN;
      end else if (total_r == '0) begin
        status = pasl_pkg::ST_TABLE_ERROR;
      end else begin
        addr_cnt  = hit_cnt_r - CW'(1);
        total_nxt = total_r - CW'(1);
        wr        = '{en: out_load, key_en: 1'b0, cnt: hit_cnt_r - CW'(1)};
      end
    end
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      start_r      <= 1'b0;
      total_r      <= '0;
      per_lim_r    <= pasl_pkg::PER_ADDR_LIMIT_RST;
      tot_lim_r    <= pasl_pkg::TOTAL_LIMIT_RST;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      start_r      <= in_fire;
      out_tvalid_r <= out_tvalid_nxt;
      if (out_load) begin
        total_r <= total_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          pasl_pkg::REG_PER_ADDR_LIMIT: per_lim_r <= cfg_wdata;
          pasl_pkg::REG_TOTAL_LIMIT:    tot_lim_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_tuser;
      key_r <= in_tdata;
    end
    if (tok[TABLE_ENTRIES].valid) begin
      hit_r      <= tok[TABLE_ENTRIES].hit;
      free_r     <= tok[TABLE_ENTRIES].free;
      hit_cnt_r  <= tok[TABLE_ENTRIES].hit_cnt;
      hit_idx_r  <= hit_idx[TABLE_ENTRIES];
      free_idx_r <= free_idx[TABLE_ENTRIES];
    end
    if (out_load) begin
      out_tdata_r <= {7'd0, total_nxt, addr_cnt, status};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_accept_scan : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_SCAN) && start_r)
    else $error("request accepted without starting a search");

  a_token_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
    tok[TABLE_ENTRIES].valid |-> (state_r == S_SCAN))
    else $error("search token arrived outside a search");

  a_write_on_load : assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> out_load && (status == pasl_pkg::ST_DONE))
    else $error("table written without a completed request");

  a_release_total : assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && cmd_r == pasl_pkg::CMD_RELEASE && status == pasl_pkg::ST_DONE)
    |=> total_r == $past(total_r) - CW'(1))
    else $error("release did not lower the total");

endmodule

>>> hdl/pasl_cell.sv
module pasl_cell #(
  parameter int IDX_W = 6,
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [pasl_pkg::KEY_W-1:0] req_key,
  input  pasl_pkg::tok_t           tok_in,
  input  logic [IDX_W-1:0]         hit_idx_in,
  input  logic [IDX_W-1:0]         free_idx_in,
  output pasl_pkg::tok_t           tok_out,
  output logic [IDX_W-1:0]         hit_idx_out,
  output logic [IDX_W-1:0]         free_idx_out,
  input  pasl_pkg::wr_t            wr,
  input  logic [IDX_W-1:0]         wr_idx
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [pasl_pkg::KEY_W-1:0] key_r;
  logic [pasl_pkg::CNT_W-1:0] cnt_r;
  pasl_pkg::tok_t             tok_r, tok_nxt;
  logic [IDX_W-1:0]           hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0]           free_idx_r, free_idx_nxt;
  logic                       live, match, sel;

  assign live  = (cnt_r != '0);
  assign match = live && (key_r == req_key);
  assign sel   = wr.en && (wr_idx == MY_IDX);

  always_comb begin
    tok_nxt      = tok_in;
    hit_idx_nxt  = hit_idx_in;
    free_idx_nxt = free_idx_in;
    if (!tok_in.hit && match) begin
      tok_nxt.hit     = 1'b1;
      tok_nxt.hit_cnt = cnt_r;
      hit_idx_nxt     = MY_IDX;
    end
    if (!tok_in.free && !live) begin
      tok_nxt.free = 1'b1;
      free_idx_nxt = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (sel) begin
        cnt_r <= wr.cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    if (sel && wr.key_en) begin
      key_r <= req_key;
    end
  end

  assign tok_out      = tok_r;
  assign hit_idx_out  = hit_idx_r;
  assign free_idx_out = free_idx_r;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int SLOTS  = pasl_pkg::TABLE_ENTRIES_DEF;
  localparam int KEY_W  = pasl_pkg::KEY_W;
  localparam int CNT_W  = pasl_pkg::CNT_W;
  localparam int STAT_W = pasl_pkg::STAT_W;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  addr_sessions;
    logic [CNT_W-1:0]  total_sessions;
  } verdict_t;

  // Tracks the session table and queues the answer each request should get.
  class session_ledger;
    logic [KEY_W-1:0] slot_key [SLOTS];
    logic [CNT_W-1:0] slot_cnt [SLOTS];
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] addr_limit;
    logic [CNT_W-1:0] total_limit;
    verdict_t         pending_verdicts[$];
    int               errors;
    int               status_seen[5];

    function new();
      foreach (slot_cnt[i]) begin
        slot_key[i] = '0;
        slot_cnt[i] = '0;
      end
      total       = '0;
      addr_limit  = pasl_pkg::PER_ADDR_LIMIT_RST;
      total_limit = pasl_pkg::TOTAL_LIMIT_RST;
      errors      = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_limit(logic idx, logic [CNT_W-1:0] val);
      if (idx == pasl_pkg::REG_PER_ADDR_LIMIT) begin
        addr_limit = val;
      end else begin
        total_limit = val;
      end
    endfunction

    function int live_slot(logic [KEY_W-1:0] key);
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_cnt[i] != '0 && slot_key[i] == key) return i;
      end
      return SLOTS;
    endfunction

    function int free_slot();
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_cnt[i] == '0) return i;
      end
      return SLOTS;
    endfunction

    // key of a random live slot, or the fallback if the table is empty
    function logic [KEY_W-1:0] live_key_or(logic [KEY_W-1:0] fallback);
      int live[$];
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_cnt[i] != '0) live.push_back(i);
      end
      if (live.size() == 0) return fallback;
      return slot_key[live[$urandom_range(0, live.size() - 1)]];
    endfunction

    function void note_request(logic cmd, logic [KEY_W-1:0] key);
      verdict_t v;
      int       hit;
      int       spare;
      hit = live_slot(key);
      v.status = pasl_pkg::ST_DONE;
      v.addr_sessions = (hit < SLOTS) ? slot_cnt[hit] : '0;
      if (cmd == pasl_pkg::CMD_ADMIT) begin
        if (total >= total_limit) begin
          v.status = pasl_pkg::ST_TOTAL_FULL;
        end else if (hit < SLOTS) begin
          if (slot_cnt[hit] >= addr_limit) begin
            v.status = pasl_pkg::ST_AT_LIMIT;
          end else begin
            slot_cnt[hit] = slot_cnt[hit] + 1'b1;
            total = total + 1'b1;
            v.addr_sessions = slot_cnt[hit];
          end
        end else begin
          spare = free_slot();
          if (spare >= SLOTS) begin
            v.status = pasl_pkg::ST_TABLE_ERROR;
          end else begin
            slot_key[spare] = key;
            slot_cnt[spare] = 7'd1;
            total = total + 1'b1;
            v.addr_sessions = 7'd1;
          end
        end
      end else if (hit >= SLOTS) begin
        v.status = pasl_pkg::ST_UNKNOWN;
      end else if (total == '0) begin
        v.status = pasl_pkg::ST_TABLE_ERROR;
      end else begin
        slot_cnt[hit] = slot_cnt[hit] - 1'b1;
        total = total - 1'b1;
        v.addr_sessions = slot_cnt[hit];
      end
      v.total_sessions = total;
      pending_verdicts.push_back(v);
    endfunction

    function void check_result(logic [23:0] data);
      verdict_t want;
      verdict_t got;
      got.status         = data[2:0];
      got.addr_sessions  = data[9:3];
      got.total_sessions = data[16:10];
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result without a request: expected none, actual %h", $time, data);
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (want.status <= pasl_pkg::ST_TABLE_ERROR) status_seen[want.status]++;
      if (got.status !== want.status) begin
        $display("%0t: status: expected %0d, actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.addr_sessions !== want.addr_sessions) begin
        $display("%0t: address_sessions: expected %0d, actual %0d",
                 $time, want.addr_sessions, got.addr_sessions);
        errors++;
      end
      if (got.total_sessions !== want.total_sessions) begin
        $display("%0t: total_sessions: expected %0d, actual %0d",
                 $time, want.total_sessions, got.total_sessions);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [6:0]  cfg_wdata = '0;

  session_ledger ledger = new();
  int sent = 0;
  int settings_used = 0;
  int tx_idle_pct = 31;
  int rx_idle_pct = 60;

  per_address_session_limiter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) ledger.check_result(out_tdata);
  end

  task automatic send_request(logic cmd, logic [KEY_W-1:0] key);
    tx_idle_pct = (sent < 417) ? 31 : (sent < 834) ? 60 : 0;
    rx_idle_pct = (sent < 417) ? 60 : (sent < 834) ? 31 : 0;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= key;
    do @(posedge clk); while (!in_tready);
    ledger.note_request(cmd, key);
    sent++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (ledger.pending_verdicts.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
  endtask

  task automatic write_limits(logic [CNT_W-1:0] addr_lim, logic [CNT_W-1:0] total_lim);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= pasl_pkg::REG_PER_ADDR_LIMIT;
    cfg_wdata <= addr_lim;
    @(posedge clk);
    ledger.set_limit(pasl_pkg::REG_PER_ADDR_LIMIT, addr_lim);
    cfg_index <= pasl_pkg::REG_TOTAL_LIMIT;
    cfg_wdata <= total_lim;
    @(posedge clk);
    ledger.set_limit(pasl_pkg::REG_TOTAL_LIMIT, total_lim);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Pool keys include one-bit neighbors of earlier keys; releases mostly hit live keys.
  task automatic run_phase(logic [CNT_W-1:0] addr_lim, logic [CNT_W-1:0] total_lim,
                           int pool_n, int admit_pct, int count);
    logic [KEY_W-1:0] pool[$];
    logic [KEY_W-1:0] key;
    logic             cmd;
    write_limits(addr_lim, total_lim);
    for (int i = 0; i < pool_n; i++) begin
      if (i > 0 && $urandom_range(0, 3) == 0) begin
        pool.push_back(pool[$urandom_range(0, i - 1)] ^ (64'd1 << $urandom_range(0, 63)));
      end else begin
        pool.push_back({$urandom, $urandom});
      end
    end
    repeat (count) begin
      cmd = ($urandom_range(0, 99) < admit_pct) ? pasl_pkg::CMD_ADMIT
                                                : pasl_pkg::CMD_RELEASE;
      key = pool[$urandom_range(0, pool_n - 1)];
      if (cmd == pasl_pkg::CMD_RELEASE && $urandom_range(0, 99) < 70) begin
        key = ledger.live_key_or(key);
      end else if ($urandom_range(0, 99) < 4) begin
        key = {$urandom, $urandom};
      end
      send_request(cmd, key);
    end
  endtask

  initial begin
    logic [KEY_W-1:0] k_zero;
    logic [KEY_W-1:0] k_ones;
    logic [KEY_W-1:0] k_odd;
    logic [KEY_W-1:0] k_near;
    logic [KEY_W-1:0] k_even;
    k_zero = '0;
    k_ones = '1;
    k_odd  = 64'h5555_5555_5555_5555;
    k_near = k_odd ^ 64'h8000_0000_0000_0000;
    k_even = 64'hAAAA_AAAA_AAAA_AAAA;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default limits: release on an empty table, per-address limit, near keys
    send_request(pasl_pkg::CMD_RELEASE, k_zero);
    repeat (5) send_request(pasl_pkg::CMD_ADMIT, k_zero);
    send_request(pasl_pkg::CMD_ADMIT, k_ones);
    send_request(pasl_pkg::CMD_ADMIT, k_odd);
    send_request(pasl_pkg::CMD_ADMIT, k_near);
    repeat (2) send_request(pasl_pkg::CMD_RELEASE, k_near);
    repeat (4) send_request(pasl_pkg::CMD_RELEASE, k_zero);
    send_request(pasl_pkg::CMD_ADMIT, k_even);

    // limits lowered: total limit at the held total, per-address limit reached
    write_limits(7'd2, 7'd3);
    send_request(pasl_pkg::CMD_ADMIT, k_ones);
    send_request(pasl_pkg::CMD_RELEASE, k_ones);
    send_request(pasl_pkg::CMD_ADMIT, k_odd);
    send_request(pasl_pkg::CMD_RELEASE, k_even);
    send_request(pasl_pkg::CMD_ADMIT, k_odd);

    // total limit zero refuses every admit
    write_limits(7'd1, 7'd0);
    send_request(pasl_pkg::CMD_ADMIT, k_ones);
    repeat (2) send_request(pasl_pkg::CMD_RELEASE, k_odd);

    run_phase(7'd1, 7'd127, 72, 90, 180);
    run_phase(7'd127, 7'd64, 3, 60, 220);
    run_phase(7'd0, 7'd127, 12, 50, 140);
    run_phase(7'd3, 7'd0, 8, 20, 120);
    run_phase(7'd64, 7'd1, 6, 50, 100);
    repeat (4) begin
      run_phase(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)),
                $urandom_range(2, 80), $urandom_range(40, 80), 120);
    end
    settle();

    $display("Summary: %0d requests under %0d limit settings", sent, settings_used + 1);
    $display("Statuses: done %0d, total full %0d, at limit %0d, unknown %0d, table error %0d",
             ledger.status_seen[pasl_pkg::ST_DONE],
             ledger.status_seen[pasl_pkg::ST_TOTAL_FULL],
             ledger.status_seen[pasl_pkg::ST_AT_LIMIT],
             ledger.status_seen[pasl_pkg::ST_UNKNOWN],
             ledger.status_seen[pasl_pkg::ST_TABLE_ERROR]);
    if (ledger.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> files.f
hdl/pasl_pkg.sv
hdl/pasl_cell.sv
hdl/per_address_session_limiter.sv
tb/testbench.sv
